### rtl/mi3_pkg.sv
// Shared constants and types for the 3x3 adjugate matrix inverse.
package mi3_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_ENTRIES    = 9;

  // Per-item flags carried alongside the divider lanes
  typedef struct packed {
    logic                   singular;
    logic [NUM_ENTRIES-1:0] qneg;
    logic [NUM_ENTRIES-1:0] ovf;
  } mi3_side_t;

endpackage

### rtl/mi3_if.sv
// Input and result channel interfaces for the 3x3 matrix inverse.
interface mi3_in_if #(
  parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] in_r1c1;
  logic signed [DATA_WIDTH-1:0] in_r1c2;
  logic signed [DATA_WIDTH-1:0] in_r1c3;
  logic signed [DATA_WIDTH-1:0] in_r2c1;
  logic signed [DATA_WIDTH-1:0] in_r2c2;
  logic signed [DATA_WIDTH-1:0] in_r2c3;
  logic signed [DATA_WIDTH-1:0] in_r3c1;
  logic signed [DATA_WIDTH-1:0] in_r3c2;
  logic signed [DATA_WIDTH-1:0] in_r3c3;

  modport source (
    output valid, in_r1c1, in_r1c2, in_r1c3, in_r2c1, in_r2c2, in_r2c3,
           in_r3c1, in_r3c2, in_r3c3,
    input  ready
  );
  modport sink (
    input  valid, in_r1c1, in_r1c2, in_r1c3, in_r2c1, in_r2c2, in_r2c3,
           in_r3c1, in_r3c2, in_r3c3,
    output ready
  );
endinterface

interface mi3_out_if #(
  parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] out_r1c1;
  logic signed [DATA_WIDTH-1:0] out_r1c2;
  logic signed [DATA_WIDTH-1:0] out_r1c3;
  logic signed [DATA_WIDTH-1:0] out_r2c1;
  logic signed [DATA_WIDTH-1:0] out_r2c2;
  logic signed [DATA_WIDTH-1:0] out_r2c3;
  logic signed [DATA_WIDTH-1:0] out_r3c1;
  logic signed [DATA_WIDTH-1:0] out_r3c2;
  logic signed [DATA_WIDTH-1:0] out_r3c3;
  logic                         singular;
  logic                         clipped;

  modport source (
    output valid, out_r1c1, out_r1c2, out_r1c3, out_r2c1, out_r2c2, out_r2c3,
           out_r3c1, out_r3c2, out_r3c3, singular, clipped,
    input  ready
  );
  modport sink (
    input  valid, out_r1c1, out_r1c2, out_r1c3, out_r2c1, out_r2c2, out_r2c3,
           out_r3c1, out_r3c2, out_r3c3, singular, clipped,
    output ready
  );
endinterface

### rtl/mi3_mul.sv
// Two-stage signed multiplier split into two partial products on operand b.
module mi3_mul #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int LW = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);
  localparam int PW  = AW + BW;
  localparam int PLW = AW + LW + 1;
  localparam int PHW = AW + BW - LW;

  logic signed [PLW-1:0] pl_r, pl_nxt;
  logic signed [PHW-1:0] ph_r, ph_nxt;
  logic signed [PW-1:0]  p_r, p_nxt;

  // Form partial products on the low unsigned and high signed slices of b
  always_comb begin
    pl_nxt = a * $signed({1'b0, b[LW-1:0]});
    ph_nxt = a * $signed(b[BW-1:LW]);
    p_nxt  = (PW'(ph_r) <<< LW) + PW'(pl_r);
  end

  // Advance both stages together
  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= pl_nxt;
      ph_r <= ph_nxt;
      p_r  <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

### rtl/mi3_div.sv
// Pipelined restoring divider: nine lanes share one divisor, one quotient bit per stage.
module mi3_div #(
  parameter int W  = 32,
  parameter int DW = 97
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_i,
  input  logic [DW-1:0]           d_i,
  input  logic [DW-1:0]           r0_i  [mi3_pkg::NUM_ENTRIES],
  input  logic [W-1:0]            nlo_i [mi3_pkg::NUM_ENTRIES],
  input  mi3_pkg::mi3_side_t      sb_i,
  output logic                    vld_o,
  output logic [W-1:0]            q_o   [mi3_pkg::NUM_ENTRIES],
  output mi3_pkg::mi3_side_t      sb_o
);
  import mi3_pkg::*;

  localparam int NL = NUM_ENTRIES;

  logic [W-1:0]  vld_r;
  logic [DW-1:0] d_r   [W];
  mi3_side_t     sb_r  [W];
  logic [DW-1:0] r_r   [W][NL];
  logic [W-1:0]  nl_r  [W][NL];
  logic [W-1:0]  q_r   [W][NL];

  // Valid bits, cleared by reset, frozen on stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[W-2:0], vld_i};
    end
  end

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic [DW-1:0] d_src;
    mi3_side_t     sb_src;
    logic [DW-1:0] r_src  [NL];
    logic [W-1:0]  nl_src [NL];
    logic [W-1:0]  q_src  [NL];

    if (s == 0) begin : g_first
      assign d_src  = d_i;
      assign sb_src = sb_i;
      for (genvar k = 0; k < NL; k++) begin : g_ln
        assign r_src[k]  = r0_i[k];
        assign nl_src[k] = nlo_i[k];
        assign q_src[k]  = '0;
      end
    end else begin : g_next
      assign d_src  = d_r[s-1];
      assign sb_src = sb_r[s-1];
      for (genvar k = 0; k < NL; k++) begin : g_ln
        assign r_src[k]  = r_r[s-1][k];
        assign nl_src[k] = nl_r[s-1][k];
        assign q_src[k]  = q_r[s-1][k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[s]  <= d_src;
        sb_r[s] <= sb_src;
      end
    end

    for (genvar k = 0; k < NL; k++) begin : g_lane
      logic [DW:0]   rs;
      logic          ge;
      logic [DW-1:0] r_nxt;

      // Shift in the next numerator bit, subtract the divisor when it fits
      always_comb begin
        rs    = {r_src[k], nl_src[k][W-1]};
        ge    = (rs >= {1'b0, d_src});
        r_nxt = ge ? DW'(rs - {1'b0, d_src}) : DW'(rs);
      end

      always_ff @(posedge clk) begin
        if (en) begin
          r_r[s][k]  <= r_nxt;
          nl_r[s][k] <= nl_src[k] << 1;
          q_r[s][k]  <= {q_src[k][W-2:0], ge};
        end
      end
    end
  end

  assign vld_o = vld_r[W-1];
  assign sb_o  = sb_r[W-1];
  for (genvar k = 0; k < NL; k++) begin : g_out
    assign q_o[k] = q_r[W-1][k];
  end

  a_entry_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_i && d_i != '0 && !sb_i.ovf[0] |-> r0_i[0] < d_i)
    else $error("divider entry remainder not below divisor");

  a_exit_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[W-1] && d_r[W-1] != '0 && !sb_r[W-1].ovf[0] |-> r_r[W-1][0] < d_r[W-1])
    else $error("divider final remainder not below divisor");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> vld_r == $past(vld_r))
    else $error("divider valid bits moved during stall");

endmodule

### rtl/matrix_inverse_3x3.sv
// Top level: pipelined 3x3 adjugate inverse, one matrix per cycle unless stalled.
//
//   channel  | dir | handshake              | payload
//   in_ch    | in  | valid/ready            | in_r1c1 .. in_r3c3, signed Q16.16
//   out_ch   | out | valid/ready            | out_r1c1 .. out_r3c3, singular, clipped
//
// The divider resolves one quotient bit per stage; a new matrix is taken every
// cycle unless out_ch stalls the pipeline.
// rst_n is synchronous: it clears the valid bits of every stage.
// When a result waits and out_ch.ready is low, all stages hold and in_ch.ready
// drops; nothing is lost or repeated.
module matrix_inverse_3x3 #(
  parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  mi3_in_if.sink          in_ch,
  mi3_out_if.source       out_ch
);
  import mi3_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int NE   = NUM_ENTRIES;
  localparam int PW   = 2 * W;
  localparam int CW   = 2 * W + 1;
  localparam int DPW  = W + CW;
  localparam int DETW = 3 * W + 2;
  localparam int DW   = 3 * W + 1;
  localparam int NW   = CW + 2 * F;
  localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

  logic adv;
  logic out_valid_r;
  logic [7:1] vp_r;

  logic signed [W-1:0]    m_in   [NE];
  logic signed [PW-1:0]   pa     [NE];
  logic signed [PW-1:0]   pb     [NE];
  logic signed [W-1:0]    m_d1_r [3];
  logic signed [W-1:0]    m_d2_r [3];
  logic signed [W-1:0]    m_d3_r [3];
  logic signed [CW-1:0]   cf_r    [NE];
  logic signed [CW-1:0]   cf_d4_r [NE];
  logic signed [CW-1:0]   cf_d5_r [NE];
  logic signed [CW-1:0]   cf_d6_r [NE];
  logic signed [DPW-1:0]  dp     [3];
  logic signed [DETW-1:0] det_r;
  logic                   det_zero_r;
  logic [DW-1:0]          dmag_r;
  logic [NW-1:0]          num_r  [NE];
  logic [NE-1:0]          qneg_r;

  logic [DW-1:0]          r0     [NE];
  logic [W-1:0]           nlo    [NE];
  mi3_side_t              side;
  logic                   div_vld;
  logic [W-1:0]           q      [NE];
  mi3_side_t              div_side;

  logic signed [W-1:0]    res    [NE];
  logic [NE-1:0]          clip_ln;
  logic signed [W-1:0]    out_r  [NE];
  logic                   singular_r;
  logic                   clipped_r;

  // Advance the whole pipeline unless a result waits
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  assign m_in[0] = in_ch.in_r1c1;
  assign m_in[1] = in_ch.in_r1c2;
  assign m_in[2] = in_ch.in_r1c3;
  assign m_in[3] = in_ch.in_r2c1;
  assign m_in[4] = in_ch.in_r2c2;
  assign m_in[5] = in_ch.in_r2c3;
  assign m_in[6] = in_ch.in_r3c1;
  assign m_in[7] = in_ch.in_r3c2;
  assign m_in[8] = in_ch.in_r3c3;

  // Valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= '0;
    end else if (adv) begin
      vp_r <= {vp_r[6:1], in_ch.valid};
    end
  end

  // Cofactor products: two per entry
  for (genvar k = 0; k < NE; k++) begin : g_cof
    localparam int I  = k / 3;
    localparam int J  = k % 3;
    localparam int I1 = (I == 0) ? 1 : 0;
    localparam int I2 = (I == 2) ? 1 : 2;
    localparam int J1 = (J == 0) ? 1 : 0;
    localparam int J2 = (J == 2) ? 1 : 2;

    mi3_mul #(.AW(W), .BW(W), .LW(W / 2)) u_mul_a (
      .clk(clk), .en(adv), .a(m_in[3*I1+J1]), .b(m_in[3*I2+J2]), .p(pa[k])
    );
    mi3_mul #(.AW(W), .BW(W), .LW(W / 2)) u_mul_b (
      .clk(clk), .en(adv), .a(m_in[3*I1+J2]), .b(m_in[3*I2+J1]), .p(pb[k])
    );

    // Take the signed difference, negate on odd positions
    always_ff @(posedge clk) begin
      if (adv) begin
        if (((I + J) % 2) != 0) begin
          cf_r[k] <= CW'(pb[k]) - CW'(pa[k]);
        end else begin
          cf_r[k] <= CW'(pa[k]) - CW'(pb[k]);
        end
        cf_d4_r[k] <= cf_r[k];
        cf_d5_r[k] <= cf_d4_r[k];
        cf_d6_r[k] <= cf_d5_r[k];
      end
    end
  end

  // Determinant: first row times its cofactors
  for (genvar k = 0; k < 3; k++) begin : g_det
    always_ff @(posedge clk) begin
      if (adv) begin
        m_d1_r[k] <= m_in[k];
        m_d2_r[k] <= m_d1_r[k];
        m_d3_r[k] <= m_d2_r[k];
      end
    end

    mi3_mul #(.AW(W), .BW(CW), .LW(W)) u_mul_d (
      .clk(clk), .en(adv), .a(m_d3_r[k]), .b(cf_r[k]), .p(dp[k])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      det_r <= DETW'(dp[0]) + DETW'(dp[1]) + DETW'(dp[2]);
    end
  end

  // Split determinant into sign and magnitude, scale the numerators
  always_ff @(posedge clk) begin
    if (adv) begin
      det_zero_r <= (det_r == '0);
      dmag_r     <= det_r[DETW-1] ? DW'($unsigned(-det_r)) : DW'($unsigned(det_r));
    end
  end

  for (genvar k = 0; k < NE; k++) begin : g_num
    localparam int T = 3 * (k % 3) + k / 3;
    logic [CW-1:0] nmag;

    assign nmag = cf_d6_r[T][CW-1] ? $unsigned(-cf_d6_r[T]) : $unsigned(cf_d6_r[T]);

    always_ff @(posedge clk) begin
      if (adv) begin
        num_r[k]  <= NW'(nmag) << (2 * F);
        qneg_r[k] <= cf_d6_r[T][CW-1] ^ det_r[DETW-1];
      end
    end

    // Quotient would need more than W bits: flag for saturation
    assign side.ovf[k] = ((num_r[k] >> W) >= dmag_r);
    assign r0[k]       = DW'(num_r[k] >> W);
    assign nlo[k]      = num_r[k][W-1:0];
  end

  assign side.qneg     = qneg_r;
  assign side.singular = det_zero_r;

  mi3_div #(.W(W), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (vp_r[7]),
    .d_i   (dmag_r),
    .r0_i  (r0),
    .nlo_i (nlo),
    .sb_i  (side),
    .vld_o (div_vld),
    .q_o   (q),
    .sb_o  (div_side)
  );

  // Saturate and apply sign per entry
  for (genvar k = 0; k < NE; k++) begin : g_sat
    logic [W-1:0] mag;

    always_comb begin
      clip_ln[k] = 1'b0;
      mag        = q[k];
      if (div_side.qneg[k]) begin
        if (div_side.ovf[k] || q[k] > LIM_NEG) begin
          mag        = LIM_NEG;
          clip_ln[k] = 1'b1;
        end
        res[k] = $signed(-mag);
      end else begin
        if (div_side.ovf[k] || q[k] > LIM_POS) begin
          mag        = LIM_POS;
          clip_ln[k] = 1'b1;
        end
        res[k] = $signed(mag);
      end
    end
  end

  // Output register: hold while the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      singular_r <= div_side.singular;
      clipped_r  <= !div_side.singular && (|clip_ln);
      for (int k = 0; k < NE; k++) begin
        out_r[k] <= div_side.singular ? '0 : res[k];
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_r1c1 = out_r[0];
  assign out_ch.out_r1c2 = out_r[1];
  assign out_ch.out_r1c3 = out_r[2];
  assign out_ch.out_r2c1 = out_r[3];
  assign out_ch.out_r2c2 = out_r[4];
  assign out_ch.out_r2c3 = out_r[5];
  assign out_ch.out_r3c1 = out_r[6];
  assign out_ch.out_r3c2 = out_r[7];
  assign out_ch.out_r3c3 = out_r[8];
  assign out_ch.singular = singular_r;
  assign out_ch.clipped  = clipped_r;

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && singular_r |-> out_r[0] == '0 && out_r[4] == '0 && out_r[8] == '0)
    else $error("singular result with nonzero entries");

  a_singular_noclip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && singular_r |-> !clipped_r)
    else $error("singular result flagged as clipped");

  a_accept_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |-> !out_valid_r || out_ch.ready)
    else $error("transaction accepted while pipeline stalled");

endmodule
